>>> hdl/gori_pkg.sv
// Package: beat types, opcodes, register indexes and sequencer states for ring inflation.
package gori_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_SIDE   = 1'b1;

    localparam int CFG_DW = 9;

    localparam logic [4:0] RADIUS_RST = 5'd3;
    localparam logic [8:0] SIDE_RST   = 9'd200;

    typedef struct packed {
        logic             opcode;
        logic [7:0]       row;
        logic [7:0]       col;
        logic signed [7:0] cell_value;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_row;
        logic [7:0] out_col;
        logic [6:0] inflated_value;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_STEP,
        ST_OCT,
        ST_DRAIN
    } state_t;

endpackage

>>> hdl/grid_obstacle_ring_inflation.sv
// Top level: cost grid memory with a midpoint-circle ring sequencer for inflated-cost queries.
//
// Cells are loaded with write beats (opcode 0), taken only while the sequencer is idle. A
// query beat (opcode 1) walks the midpoint-circle outline of the configured radius around
// the cell, reading the cost memory in the axis and octant states, and returns the largest
// of zero and the in-bounds ring costs. The walk reads the four axis cells, then for each of
// about 0.71 * radius ring steps passes the step state and reads eight cells, or four where
// the ring meets the diagonal on the last step; a query outside the map goes straight to the
// drain state. No new beat is taken until a query has finished. A finished result sits in an
// output register so that the next beat can be taken while it waits. Cells never written
// read as anything.
module grid_obstacle_ring_inflation
    import gori_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int MAX_RADIUS = 31
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_beat_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_beat_t         m_data
);

    localparam int IW    = $clog2(MAX_SIDE);
    localparam int DEPTH = 2 ** (2 * IW);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = $clog2(MAX_SIDE + 256 + MAX_RADIUS) + 1;
    localparam int FW    = RW + 4;

    logic [7:0] mem_q [DEPTH];

    logic [4:0]  radius_reg;
    logic [8:0]  side_reg;
    state_t      state_reg, state_next;
    logic [2:0]  k_reg, k_next;
    logic [RW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [FW-1:0] f_reg, f_next;
    logic [7:0]  r0_reg, c0_reg;
    logic [6:0]  best_reg, best_next;
    logic        pv_reg;
    logic [7:0]  rd_data_reg;
    logic        m_valid_reg, m_valid_next;
    out_beat_t   m_data_reg;

    logic [RW-1:0] rad_eff;
    logic [SW-1:0] side_eff;
    logic          s_fire, q_fire, w_fire, q_inb, w_inb, out_free;
    logic [2:0]    k_last;
    logic signed [RW:0] dr, dc;
    logic signed [CW-1:0] r_probe, c_probe, side_s;
    logic          probe_en;
    logic          f_ge;
    logic [RW-1:0] y_dec;
    logic signed [FW-1:0] ddy_term, ddx_term;

    always_comb begin
        if ({3'd0, radius_reg} > 8'(MAX_RADIUS)) begin
            rad_eff = RW'(MAX_RADIUS);
        end else begin
            rad_eff = RW'(radius_reg);
        end
        if (11'(side_reg) > 11'(MAX_SIDE)) begin
            side_eff = SW'(MAX_SIDE);
        end else begin
            side_eff = SW'(side_reg);
        end
    end

    assign side_s   = $signed(CW'(side_eff));
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign q_fire   = s_fire && (s_data.opcode == OP_QUERY);
    assign w_fire   = s_fire && (s_data.opcode == OP_WRITE);
    assign q_inb    = (CW'(s_data.row) < CW'(side_eff)) && (CW'(s_data.col) < CW'(side_eff));
    assign w_inb    = q_inb;
    assign out_free = !m_valid_reg || m_ready;
    assign k_last   = (x_reg != y_reg) ? 3'd7 : 3'd3;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_fire) begin
                    state_next = q_inb ? ST_AXIS : ST_DRAIN;
                end
            end
            ST_AXIS: begin
                if (k_reg == 3'd3) begin
                    state_next = (x_reg < y_reg) ? ST_STEP : ST_DRAIN;
                end
            end
            ST_STEP: state_next = ST_OCT;
            ST_OCT: begin
                if (k_reg == k_last) begin
                    state_next = (x_reg < y_reg) ? ST_STEP : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Ring offsets and step arithmetic
    always_comb begin
        dr = '0;
        dc = '0;
        if (state_reg == ST_AXIS) begin
            case (k_reg[1:0])
                2'd0: dc =  $signed({1'b0, rad_eff});
                2'd1: dc = -$signed({1'b0, rad_eff});
                2'd2: dr =  $signed({1'b0, rad_eff});
                2'd3: dr = -$signed({1'b0, rad_eff});
                default: dr = '0;
            endcase
        end else begin
            case (k_reg)
                3'd0: begin dr =  $signed({1'b0, x_reg}); dc =  $signed({1'b0, y_reg}); end
                3'd1: begin dr = -$signed({1'b0, x_reg}); dc =  $signed({1'b0, y_reg}); end
                3'd2: begin dr =  $signed({1'b0, x_reg}); dc = -$signed({1'b0, y_reg}); end
                3'd3: begin dr = -$signed({1'b0, x_reg}); dc = -$signed({1'b0, y_reg}); end
                3'd4: begin dr =  $signed({1'b0, y_reg}); dc =  $signed({1'b0, x_reg}); end
                3'd5: begin dr = -$signed({1'b0, y_reg}); dc =  $signed({1'b0, x_reg}); end
                3'd6: begin dr =  $signed({1'b0, y_reg}); dc = -$signed({1'b0, x_reg}); end
                3'd7: begin dr = -$signed({1'b0, y_reg}); dc = -$signed({1'b0, x_reg}); end
                default: dr = '0;
            endcase
        end
    end

    assign r_probe  = $signed(CW'(r0_reg)) + CW'(dr);
    assign c_probe  = $signed(CW'(c0_reg)) + CW'(dc);
    assign probe_en = ((state_reg == ST_AXIS) || (state_reg == ST_OCT))
                      && !r_probe[CW-1] && !c_probe[CW-1]
                      && (r_probe < side_s) && (c_probe < side_s);

    assign f_ge     = !f_reg[FW-1];
    assign y_dec    = f_ge ? (y_reg - RW'(1)) : y_reg;
    assign ddy_term = f_ge ? -$signed(FW'({y_dec, 1'b0})) : '0;
    assign ddx_term = $signed(FW'({x_reg + RW'(1), 1'b0})) + FW'(1);

    // Outputs of the sequencer
    always_comb begin
        k_next       = k_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        f_next       = f_reg;
        best_next    = best_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (pv_reg && ($signed(rd_data_reg) > $signed({1'b0, best_reg}))) begin
            best_next = rd_data_reg[6:0];
        end
        case (state_reg)
            ST_IDLE: begin
                k_next    = '0;
                x_next    = '0;
                y_next    = rad_eff;
                f_next    = FW'(1) - $signed(FW'(rad_eff));
                best_next = '0;
            end
            ST_AXIS: k_next = k_reg + 3'd1;
            ST_STEP: begin
                k_next = '0;
                x_next = x_reg + RW'(1);
                y_next = y_dec;
                f_next = f_reg + ddy_term + ddx_term;
            end
            ST_OCT: k_next = k_reg + 3'd1;
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: k_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RADIUS_RST;
            side_reg    <= SIDE_RST;
            state_reg   <= ST_IDLE;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_RADIUS: radius_reg <= cfg_wdata[4:0];
                    REG_SIDE:   side_reg   <= cfg_wdata;
                    default:    side_reg   <= side_reg;
                endcase
            end
            state_reg   <= state_next;
            pv_reg      <= probe_en;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        f_reg    <= f_next;
        best_reg <= best_next;
        if (q_fire) begin
            r0_reg <= s_data.row;
            c0_reg <= s_data.col;
        end
        if ((state_reg == ST_DRAIN) && out_free) begin
            m_data_reg.out_row        <= r0_reg;
            m_data_reg.out_col        <= c0_reg;
            m_data_reg.inflated_value <= best_next;
        end
    end

    // Cost memory: writes only while idle; reads every cycle, used only for flagged ring reads
    always_ff @(posedge aclk) begin
        if (w_fire && w_inb) begin
            mem_q[{IW'(s_data.row), IW'(s_data.col)}] <= s_data.cell_value;
        end
        rd_data_reg <= mem_q[{IW'(r_probe), IW'(c_probe)}];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_probe_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> ($past(state_reg) == ST_AXIS || $past(state_reg) == ST_OCT))
        else $error("read data flagged without a ring read issued");

    // the last step may cross the diagonal by one cell
    a_octant_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OCT) |-> ({1'b0, x_reg} <= {1'b0, y_reg} + (RW+1)'(1)))
        else $error("ring walk past the diagonal");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pv_reg)
        else $error("ring read pending while accepting beats");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished query not presented");

endmodule
